FILE: rtl/bkr_pkg.sv
package bkr_pkg;

    localparam int KEY_SLOTS = 6;

    // Operation codes of an input request.
    localparam logic [1:0] OP_REPORT = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_DROP   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_REPEAT_DELAY  = 1'b0;
    localparam logic CFG_REPEAT_PERIOD = 1'b1;

    localparam logic [15:0] REPEAT_DELAY_RESET  = 16'd400;
    localparam logic [15:0] REPEAT_PERIOD_RESET = 16'd45;

    // Usage codes with a meaning of their own.
    localparam logic [7:0] USAGE_EMPTY     = 8'h00;
    localparam logic [7:0] USAGE_ROLLOVER  = 8'h01;
    localparam logic [7:0] USAGE_ENTER     = 8'h28;
    localparam logic [7:0] USAGE_ESC       = 8'h29;
    localparam logic [7:0] USAGE_BACKSPACE = 8'h2A;
    localparam logic [7:0] USAGE_TAB       = 8'h2B;
    localparam logic [7:0] USAGE_RIGHT     = 8'h4F;
    localparam logic [7:0] USAGE_LEFT      = 8'h50;
    localparam logic [7:0] USAGE_DOWN      = 8'h51;
    localparam logic [7:0] USAGE_UP        = 8'h52;

    localparam logic [7:0] SHIFT_MASK = 8'h22;

    localparam logic [4:0] LEN_MIN_LINK   = 5'd1;
    localparam logic [4:0] LEN_MIN_DECODE = 5'd8;
    localparam logic [4:0] LEN_MAX        = 5'd16;

    // Event kinds.
    localparam logic [3:0] KIND_ENTER        = 4'd0;
    localparam logic [3:0] KIND_ESC          = 4'd1;
    localparam logic [3:0] KIND_BACKSPACE    = 4'd2;
    localparam logic [3:0] KIND_TAB          = 4'd3;
    localparam logic [3:0] KIND_RIGHT        = 4'd4;
    localparam logic [3:0] KIND_LEFT         = 4'd5;
    localparam logic [3:0] KIND_DOWN         = 4'd6;
    localparam logic [3:0] KIND_UP           = 4'd7;
    localparam logic [3:0] KIND_CHAR         = 4'd8;
    localparam logic [3:0] KIND_DISCONNECTED = 4'd9;

    typedef struct packed {
        logic [1:0] op;
        logic [4:0] report_length;
        logic [7:0] modifier_bits;
        logic [7:0] key_0;
        logic [7:0] key_1;
        logic [7:0] key_2;
        logic [7:0] key_3;
        logic [7:0] key_4;
        logic [7:0] key_5;
    } in_item_t;

    typedef struct packed {
        logic [3:0] event_kind;
        logic [7:0] key_usage;
        logic       shift_held;
        logic       is_repeat;
        logic       last_of_run;
    } out_item_t;

    // All events caused by one request, one slot per key position.
    typedef struct packed {
        logic [KEY_SLOTS-1:0]            mask;
        out_item_t [KEY_SLOTS-1:0]       ev;
    } batch_t;

    typedef struct packed {
        logic held_active;
        logic link_up;
    } status_t;

    function automatic logic [3:0] kind_of(input logic [7:0] usage);
        logic [3:0] kind;
        unique case (usage)
            USAGE_ENTER:     kind = KIND_ENTER;
            USAGE_ESC:       kind = KIND_ESC;
            USAGE_BACKSPACE: kind = KIND_BACKSPACE;
            USAGE_TAB:       kind = KIND_TAB;
            USAGE_RIGHT:     kind = KIND_RIGHT;
            USAGE_LEFT:      kind = KIND_LEFT;
            USAGE_DOWN:      kind = KIND_DOWN;
            USAGE_UP:        kind = KIND_UP;
            default:         kind = KIND_CHAR;
        endcase
        return kind;
    endfunction

endpackage

FILE: rtl/bkr_core.sv
module bkr_core #(
    parameter int TIME_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  bkr_pkg::in_item_t item,
    input  logic [15:0]       delay_ms,
    input  logic [15:0]       period_ms,
    output bkr_pkg::batch_t   batch,
    output bkr_pkg::status_t  status
);
    import bkr_pkg::*;

    logic [7:0]           prev_keys_reg [KEY_SLOTS];
    logic [7:0]           prev_keys_next [KEY_SLOTS];
    logic [7:0]           held_key_reg, held_key_next;
    logic [7:0]           held_mods_reg, held_mods_next;
    logic [TIME_BITS-1:0] due_reg, due_next;
    logic [TIME_BITS-1:0] ms_reg, ms_next;
    logic                 link_reg, link_next;

    logic [7:0]           keys [KEY_SLOTS];
    logic [KEY_SLOTS-1:0] new_key;
    logic [TIME_BITS-1:0] tick_diff;

    assign keys[0] = item.key_0;
    assign keys[1] = item.key_1;
    assign keys[2] = item.key_2;
    assign keys[3] = item.key_3;
    assign keys[4] = item.key_4;
    assign keys[5] = item.key_5;

    // A slot is new when it holds a real usage absent from the last decoded report.
    always_comb
    begin
        logic seen;
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            seen = 1'b0;
            for (int j = 0; j < KEY_SLOTS; j++)
            begin
                if (prev_keys_reg[j] == keys[i])
                begin
                    seen = 1'b1;
                end
            end
            new_key[i] = (keys[i] != USAGE_EMPTY) && (keys[i] != USAGE_ROLLOVER) && !seen;
        end
    end

    assign tick_diff = (ms_reg + TIME_BITS'(1)) - due_reg;

    always_comb
    begin
        logic       any_new;
        logic       still;
        logic [7:0] last_new;
        prev_keys_next = prev_keys_reg;
        held_key_next  = held_key_reg;
        held_mods_next = held_mods_reg;
        due_next       = due_reg;
        ms_next        = ms_reg;
        link_next      = link_reg;
        batch.mask     = '0;
        any_new        = 1'b0;
        still          = 1'b0;
        last_new       = USAGE_EMPTY;
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            batch.ev[i].event_kind  = kind_of(keys[i]);
            batch.ev[i].key_usage   = keys[i];
            batch.ev[i].shift_held  = (item.modifier_bits & SHIFT_MASK) != 8'h00;
            batch.ev[i].is_repeat   = 1'b0;
            batch.ev[i].last_of_run = 1'b0;
        end

        unique case (item.op)
            OP_REPORT:
            begin
                if (item.report_length >= LEN_MIN_LINK && item.report_length <= LEN_MAX)
                begin
                    link_next = 1'b1;
                end
                if (item.report_length >= LEN_MIN_DECODE && item.report_length <= LEN_MAX)
                begin
                    batch.mask = new_key;
                    for (int i = 0; i < KEY_SLOTS; i++)
                    begin
                        if (new_key[i])
                        begin
                            any_new  = 1'b1;
                            last_new = keys[i];
                        end
                        if (keys[i] == held_key_reg)
                        begin
                            still = 1'b1;
                        end
                        prev_keys_next[i] = keys[i];
                    end
                    // The new press in the highest slot always becomes held, since it is in this report.
                    if (any_new)
                    begin
                        held_key_next  = last_new;
                        held_mods_next = item.modifier_bits;
                        due_next       = ms_reg + TIME_BITS'(delay_ms);
                    end
                    else if (!still)
                    begin
                        held_key_next = USAGE_EMPTY;
                    end
                end
            end
            OP_TICK:
            begin
                ms_next = ms_reg + TIME_BITS'(1);
                if (held_key_reg != USAGE_EMPTY && link_reg && !tick_diff[TIME_BITS-1])
                begin
                    batch.mask[0]          = 1'b1;
                    batch.ev[0].event_kind = kind_of(held_key_reg);
                    batch.ev[0].key_usage  = held_key_reg;
                    batch.ev[0].shift_held = (held_mods_reg & SHIFT_MASK) != 8'h00;
                    batch.ev[0].is_repeat  = 1'b1;
                    due_next = ms_next + TIME_BITS'(period_ms);
                end
            end
            OP_DROP:
            begin
                held_key_next          = USAGE_EMPTY;
                link_next              = 1'b0;
                batch.mask[0]          = 1'b1;
                batch.ev[0].event_kind = KIND_DISCONNECTED;
                batch.ev[0].key_usage  = USAGE_EMPTY;
                batch.ev[0].shift_held = 1'b0;
                batch.ev[0].is_repeat  = 1'b0;
            end
            default:
            begin
                batch.mask = '0;
            end
        endcase

        // The highest pending slot closes the run.
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            batch.ev[i].last_of_run = batch.mask[i] &&
                ((batch.mask >> (i + 1)) == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEY_SLOTS; i++)
            begin
                prev_keys_reg[i] <= USAGE_EMPTY;
            end
            held_key_reg  <= USAGE_EMPTY;
            held_mods_reg <= 8'h00;
            due_reg       <= '0;
            ms_reg        <= '0;
            link_reg      <= 1'b0;
        end
        else if (fire)
        begin
            prev_keys_reg <= prev_keys_next;
            held_key_reg  <= held_key_next;
            held_mods_reg <= held_mods_next;
            due_reg       <= due_next;
            ms_reg        <= ms_next;
            link_reg      <= link_next;
        end
    end

    assign status.held_active = held_key_reg != USAGE_EMPTY;
    assign status.link_up     = link_reg;

endmodule

FILE: rtl/bkr_emit.sv
module bkr_emit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  bkr_pkg::batch_t    batch,
    output logic               free,
    output logic               out_valid,
    input  logic               out_stall,
    output bkr_pkg::out_item_t out_item
);
    import bkr_pkg::*;

    logic [KEY_SLOTS-1:0]      pend_mask_reg, pend_mask_next;
    out_item_t [KEY_SLOTS-1:0] pend_ev_reg;
    logic                      out_valid_reg, out_valid_next;
    out_item_t                 out_reg;

    logic [KEY_SLOTS-1:0] low_bit;
    logic [KEY_SLOTS-1:0] pend_after;
    logic                 move;
    out_item_t            sel_ev;

    assign low_bit = pend_mask_reg & (~pend_mask_reg + KEY_SLOTS'(1));
    assign move    = (pend_mask_reg != '0) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        sel_ev = '0;
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            if (low_bit[i])
            begin
                sel_ev = sel_ev | pend_ev_reg[i];
            end
        end
    end

    assign pend_after     = move ? (pend_mask_reg & ~low_bit) : pend_mask_reg;
    assign free           = pend_after == '0;
    assign pend_mask_next = fire ? batch.mask : pend_after;
    assign out_valid_next = move || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_mask_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_mask_reg <= pend_mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            pend_ev_reg <= batch.ev;
        end
        if (move)
        begin
            out_reg <= sel_ev;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

FILE: rtl/boot_keyboard_report_repeat_unit.sv
// Input, pending and output registers lie in turn between a request and its results.
// Throughput: one request per cycle while each gives at most one result and the output
// does not stall; a report with n new presses holds the input until its last result
// leaves the pending register, since the output register takes one result per cycle.
// Reset clears key history, held key, time, link flag and all pending results, and
// loads the repeat delay and period with 400 and 45 ms.
module boot_keyboard_report_repeat_unit #(
    parameter int TIME_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  bkr_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output bkr_pkg::out_item_t out_item,
    input  logic               cfg_write,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data
);
    import bkr_pkg::*;

    in_item_t    item_reg;
    logic        item_valid_reg, item_valid_next;
    logic [15:0] delay_reg;
    logic [15:0] period_reg;

    batch_t  batch;
    status_t status;
    logic    free;
    logic    fire;
    logic    take;

    assign fire            = item_valid_reg && free;
    assign in_stall        = item_valid_reg && !free;
    assign take            = in_valid && !in_stall;
    assign item_valid_next = take || (item_valid_reg && !fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            delay_reg      <= REPEAT_DELAY_RESET;
            period_reg     <= REPEAT_PERIOD_RESET;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_REPEAT_DELAY:  delay_reg  <= cfg_data;
                    CFG_REPEAT_PERIOD: period_reg <= cfg_data;
                    default:           delay_reg  <= delay_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= in_item;
        end
    end

    bkr_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (item_reg),
        .delay_ms  (delay_reg),
        .period_ms (period_reg),
        .batch     (batch),
        .status    (status)
    );

    bkr_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .batch     (batch),
        .free      (free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    // A key can only be held after a decoded report, which also brings the link up.
    assert property (@(posedge clk) disable iff (!rst_n)
        status.held_active |-> status.link_up)
        else $error("held key without link");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.is_repeat || out_item.event_kind == KIND_DISCONNECTED)
        |-> out_item.last_of_run)
        else $error("single-result request not closed");

    assert property (@(posedge clk) disable iff (!rst_n)
        fire && item_reg.op == OP_DROP |=> !status.link_up && !status.held_active)
        else $error("drop left link or held key");

    assert property (@(posedge clk) disable iff (!rst_n)
        fire && item_reg.op == OP_UNUSED |=> free)
        else $error("unused op produced results");

endmodule

FILE: tb/boot_keyboard_report_repeat_unit_test.sv
module boot_keyboard_report_repeat_unit_test;

    import bkr_pkg::*;

    // Predicts the key events of the decoder and holds those not yet seen.
    class key_event_scoreboard;
        logic [7:0]  prev_keys [KEY_SLOTS];
        logic [7:0]  held_key;
        logic [7:0]  held_mods;
        logic [31:0] now_ms;
        logic [31:0] due_ms;
        logic        link_up;
        logic [15:0] delay_ms;
        logic [15:0] period_ms;
        out_item_t   pending [$];
        int          errors;
        int          presses;
        int          repeats;
        int          drops;
        int          requests;
        int          checked;

        function new();
            foreach (prev_keys[i])
                prev_keys[i] = USAGE_EMPTY;
            held_key  = USAGE_EMPTY;
            held_mods = 8'h00;
            now_ms    = 32'd0;
            due_ms    = 32'd0;
            link_up   = 1'b0;
            delay_ms  = REPEAT_DELAY_RESET;
            period_ms = REPEAT_PERIOD_RESET;
            errors    = 0;
            presses   = 0;
            repeats   = 0;
            drops     = 0;
            requests  = 0;
            checked   = 0;
        endfunction

        function void set_register(logic index, logic [15:0] value);
            if (index == CFG_REPEAT_DELAY)
                delay_ms = value;
            else
                period_ms = value;
        endfunction

        function logic [3:0] kind_for(logic [7:0] usage);
            case (usage)
                USAGE_ENTER:     return KIND_ENTER;
                USAGE_ESC:       return KIND_ESC;
                USAGE_BACKSPACE: return KIND_BACKSPACE;
                USAGE_TAB:       return KIND_TAB;
                USAGE_RIGHT:     return KIND_RIGHT;
                USAGE_LEFT:      return KIND_LEFT;
                USAGE_DOWN:      return KIND_DOWN;
                USAGE_UP:        return KIND_UP;
                default:         return KIND_CHAR;
            endcase
        endfunction

        function out_item_t key_event(logic [3:0] kind, logic [7:0] usage,
                                      logic [7:0] mods, logic rep);
            out_item_t ev;
            ev.event_kind  = kind;
            ev.key_usage   = usage;
            ev.shift_held  = (mods & SHIFT_MASK) != 8'h00;
            ev.is_repeat   = rep;
            ev.last_of_run = 1'b0;
            return ev;
        endfunction

        function void note_request(in_item_t r);
            logic [7:0]  keys [KEY_SLOTS];
            out_item_t   caused [KEY_SLOTS];
            logic [31:0] late;
            logic        seen;
            logic        still;
            int          n;
            n = 0;
            requests++;
            keys[0] = r.key_0;
            keys[1] = r.key_1;
            keys[2] = r.key_2;
            keys[3] = r.key_3;
            keys[4] = r.key_4;
            keys[5] = r.key_5;
            case (r.op)
                OP_REPORT:
                begin
                    if (r.report_length >= LEN_MIN_LINK && r.report_length <= LEN_MAX)
                    begin
                        link_up = 1'b1;
                        if (r.report_length >= LEN_MIN_DECODE)
                        begin
                            for (int i = 0; i < KEY_SLOTS; i++)
                            begin
                                if (keys[i] != USAGE_EMPTY && keys[i] != USAGE_ROLLOVER)
                                begin
                                    seen = 1'b0;
                                    for (int j = 0; j < KEY_SLOTS; j++)
                                        if (prev_keys[j] == keys[i])
                                            seen = 1'b1;
                                    if (!seen)
                                    begin
                                        caused[n] = key_event(kind_for(keys[i]), keys[i],
                                                              r.modifier_bits, 1'b0);
                                        n++;
                                        presses++;
                                        held_key  = keys[i];
                                        held_mods = r.modifier_bits;
                                        due_ms    = now_ms + 32'(delay_ms);
                                    end
                                end
                            end
                            still = 1'b0;
                            if (held_key != USAGE_EMPTY)
                                for (int j = 0; j < KEY_SLOTS; j++)
                                    if (keys[j] == held_key)
                                        still = 1'b1;
                            if (!still)
                                held_key = USAGE_EMPTY;
                            prev_keys = keys;
                        end
                    end
                end
                OP_TICK:
                begin
                    now_ms = now_ms + 32'd1;
                    if (held_key != USAGE_EMPTY && link_up)
                    begin
                        // The deadline counts as reached while the wrapped difference
                        // is not negative.
                        late = now_ms - due_ms;
                        if (!late[31])
                        begin
                            caused[n] = key_event(kind_for(held_key), held_key,
                                                  held_mods, 1'b1);
                            n++;
                            repeats++;
                            due_ms = now_ms + 32'(period_ms);
                        end
                    end
                end
                OP_DROP:
                begin
                    held_key = USAGE_EMPTY;
                    link_up  = 1'b0;
                    caused[n] = key_event(KIND_DISCONNECTED, 8'h00, 8'h00, 1'b0);
                    n++;
                    drops++;
                end
                default:
                    ;
            endcase
            if (n > 0)
                caused[n-1].last_of_run = 1'b1;
            for (int i = 0; i < n; i++)
                pending.push_back(caused[i]);
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing expected, got %p", $time, got);
                return;
            end
            want = pending.pop_front();
            checked++;
            check_field("event_kind", 32'(want.event_kind), 32'(got.event_kind));
            check_field("key_usage", 32'(want.key_usage), 32'(got.key_usage));
            check_field("shift_held", 32'(want.shift_held), 32'(got.shift_held));
            check_field("is_repeat", 32'(want.is_repeat), 32'(got.is_repeat));
            check_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_item;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_item;
    logic        cfg_write;
    logic        cfg_index;
    logic [15:0] cfg_data;

    key_event_scoreboard board = new();

    logic [7:0] recent_keys [KEY_SLOTS];
    int         burst_left;
    logic       gappy;
    int         settings_used;

    boot_keyboard_report_repeat_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            board.check_result(out_item);

    // The receiver stalls in stretches: none, light, heavy or periodic.
    initial
    begin
        int mode;
        int left;
        out_stall = 1'b0;
        mode = 0;
        left = 0;
        forever
        begin
            @(posedge clk);
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 120);
            end
            left--;
            case (mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 99) < 30);
                2: out_stall <= ($urandom_range(0, 99) < 75);
                default: out_stall <= (left % 4 == 0);
            endcase
        end
    end

    function automatic in_item_t make_request(logic [1:0] op, logic [4:0] len,
                                              logic [7:0] mods,
                                              logic [7:0] k0, logic [7:0] k1,
                                              logic [7:0] k2, logic [7:0] k3,
                                              logic [7:0] k4, logic [7:0] k5);
        in_item_t r;
        r.op            = op;
        r.report_length = len;
        r.modifier_bits = mods;
        r.key_0         = k0;
        r.key_1         = k1;
        r.key_2         = k2;
        r.key_3         = k3;
        r.key_4         = k4;
        r.key_5         = k5;
        return r;
    endfunction

    function automatic logic [7:0] named_usage(int pick);
        case (pick)
            0: return USAGE_ENTER;
            1: return USAGE_ESC;
            2: return USAGE_BACKSPACE;
            3: return USAGE_TAB;
            4: return USAGE_RIGHT;
            5: return USAGE_LEFT;
            6: return USAGE_DOWN;
            default: return USAGE_UP;
        endcase
    endfunction

    // A small pool of usages, so that keys recur across reports and repeats get going.
    function automatic logic [7:0] random_usage();
        case ($urandom_range(0, 9))
            0, 1: return USAGE_EMPTY;
            2: return USAGE_ROLLOVER;
            3, 4: return named_usage($urandom_range(0, 7));
            5, 6, 7: return 8'($urandom_range(4, 10));
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic in_item_t noise_request(logic [1:0] op, logic [4:0] len);
        return make_request(op, len, 8'($urandom), 8'($urandom), 8'($urandom),
                            8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    function automatic in_item_t random_request();
        logic [7:0] keys [KEY_SLOTS];
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return noise_request(OP_TICK, 5'($urandom));
        if (pick < 88)
        begin
            // Mostly the previous report with a few slots changed.
            for (int i = 0; i < KEY_SLOTS; i++)
                keys[i] = ($urandom_range(0, 9) < 7) ? recent_keys[i] : random_usage();
            recent_keys = keys;
            return make_request(OP_REPORT, 5'($urandom_range(8, 16)), 8'($urandom),
                                keys[0], keys[1], keys[2], keys[3], keys[4], keys[5]);
        end
        if (pick < 93)
        begin
            case ($urandom_range(0, 2))
                0: return noise_request(OP_REPORT, 5'd0);
                1: return noise_request(OP_REPORT, 5'($urandom_range(1, 7)));
                default: return noise_request(OP_REPORT, 5'($urandom_range(17, 31)));
            endcase
        end
        if (pick < 97)
            return noise_request(OP_DROP, 5'($urandom));
        return noise_request(OP_UNUSED, 5'($urandom));
    endfunction

    // Holds the request until it is taken, then, in gappy phases, opens a gap once the burst is over.
    task automatic send_request(input in_item_t r);
        int gap;
        in_valid <= 1'b1;
        in_item  <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_request(r);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = gappy ? $urandom_range(1, 6) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        else
            burst_left--;
    endtask

    // Waits for every expected result, then waits on so that a request that gives no
    // result can also leave the pipeline.
    task automatic settle();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (6) @(posedge clk);
    endtask

    task automatic write_repeat_rates(input logic [15:0] delay, input logic [15:0] period);
        cfg_write <= 1'b1;
        cfg_index <= CFG_REPEAT_DELAY;
        cfg_data  <= delay;
        @(posedge clk);
        board.set_register(CFG_REPEAT_DELAY, delay);
        cfg_index <= CFG_REPEAT_PERIOD;
        cfg_data  <= period;
        @(posedge clk);
        board.set_register(CFG_REPEAT_PERIOD, period);
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    task automatic random_phase(input logic [15:0] delay, input logic [15:0] period,
                                input int count);
        settle();
        write_repeat_rates(delay, period);
        gappy = 1'($urandom_range(0, 1));
        for (int i = 0; i < count; i++)
            send_request(random_request());
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_item    = '0;
        cfg_write  = 1'b0;
        cfg_index  = CFG_REPEAT_DELAY;
        cfg_data   = 16'h0000;
        burst_left = 0;
        gappy      = 1'b1;
        settings_used = 1;
        foreach (recent_keys[i])
            recent_keys[i] = USAGE_EMPTY;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset delay and period.
        send_request(make_request(OP_TICK, 5'd0, 8'h00, 8'h00, 8'h00, 8'h00,
                                  8'h00, 8'h00, 8'h00));
        send_request(make_request(OP_REPORT, 5'd0, 8'h02, 8'h04, 8'h05, 8'h00,
                                  8'h00, 8'h00, 8'h00));
        send_request(make_request(OP_REPORT, 5'd31, 8'h02, 8'h04, 8'h05, 8'h00,
                                  8'h00, 8'h00, 8'h00));
        send_request(make_request(OP_REPORT, 5'd17, 8'h00, 8'h06, 8'h00, 8'h00,
                                  8'h00, 8'h00, 8'h00));
        send_request(make_request(OP_REPORT, 5'd4, 8'h00, 8'h07, 8'h00, 8'h00,
                                  8'h00, 8'h00, 8'h00));
        send_request(make_request(OP_REPORT, 5'd8, 8'h02, USAGE_ENTER, USAGE_ESC,
                                  USAGE_BACKSPACE, USAGE_TAB, USAGE_RIGHT, USAGE_LEFT));
        send_request(make_request(OP_REPORT, 5'd16, 8'h20, USAGE_DOWN, USAGE_UP,
                                  USAGE_ENTER, USAGE_ESC, USAGE_ROLLOVER, USAGE_EMPTY));
        // The same new usage in two slots gives two presses.
        send_request(make_request(OP_REPORT, 5'd8, 8'hFF, 8'hFF, 8'hFF, 8'h04,
                                  USAGE_ROLLOVER, USAGE_EMPTY, USAGE_EMPTY));
        send_request(make_request(OP_REPORT, 5'd8, 8'hDD, 8'h04, 8'h80, 8'h7F,
                                  USAGE_EMPTY, USAGE_EMPTY, USAGE_EMPTY));
        send_request(make_request(OP_REPORT, 5'd8, 8'h00, USAGE_ROLLOVER, USAGE_ROLLOVER,
                                  USAGE_ROLLOVER, USAGE_ROLLOVER, USAGE_ROLLOVER,
                                  USAGE_ROLLOVER));
        send_request(make_request(OP_REPORT, 5'd8, 8'h00, 8'h00, 8'h00, 8'h00,
                                  8'h00, 8'h00, 8'h00));
        send_request(make_request(OP_REPORT, 5'd8, 8'h00, 8'h05, 8'h00, 8'h00,
                                  8'h00, 8'h00, 8'h00));
        send_request(noise_request(OP_TICK, 5'd0));
        send_request(noise_request(OP_TICK, 5'd31));
        send_request(noise_request(OP_DROP, 5'd8));
        send_request(noise_request(OP_TICK, 5'd8));
        // After a drop the key history is kept, so the same key is not new.
        send_request(make_request(OP_REPORT, 5'd8, 8'h00, 8'h05, 8'h00, 8'h00,
                                  8'h00, 8'h00, 8'h00));
        send_request(make_request(OP_REPORT, 5'd1, 8'h00, 8'h00, 8'h00, 8'h00,
                                  8'h00, 8'h00, 8'h00));
        send_request(noise_request(OP_UNUSED, 5'd9));
        send_request(make_request(OP_REPORT, 5'd9, 8'h22, 8'h06, 8'h00, 8'h00,
                                  8'h00, 8'h00, 8'h00));
        send_request(noise_request(OP_DROP, 5'd0));
        send_request(make_request(OP_REPORT, 5'd16, 8'h00, 8'h00, 8'h00, 8'h00,
                                  8'h00, 8'h00, 8'h09));

        // Zero delay and period make a held key due on every tick.
        random_phase(16'd0, 16'd0, 57);
        random_phase(16'd1, 16'd1, 57);
        random_phase(16'hFFFF, 16'hFFFF, 57);
        random_phase(16'($urandom_range(2, 10)), 16'($urandom_range(1, 6)), 57);
        random_phase(16'd3, 16'hFFFF, 57);

        settle();
        if (board.pending.size() != 0)
        begin
            board.errors += board.pending.size();
            $display("%0t: %0d expected results never arrived", $time,
                     board.pending.size());
        end
        $display("Ran %0d requests over %0d repeat settings; checked %0d results",
                 board.requests, settings_used, board.checked);
        $display("of which %0d presses, %0d repeats and %0d disconnects",
                 board.presses, board.repeats, board.drops);
        if (board.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
